/* hdl/affine_vector_transform_core_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the affine vector transform core
// Immediate-style wrappers around concurrent properties; compiled out when
// NO_ASSERTIONS is defined.
// ---------------------------------------------------------------------------
`ifndef AFFINE_VECTOR_TRANSFORM_CORE_ASSERT_SVH
`define AFFINE_VECTOR_TRANSFORM_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define AVT_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define AVT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define AVT_ASSERT_NOW(lbl, ante, cons)
`define AVT_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

/* hdl/avt_pkg.sv */
// ---------------------------------------------------------------------------
// avt_pkg
// Shared types, widths and codes of the affine vector transform core.
// ---------------------------------------------------------------------------
package avt_pkg;

  localparam int DATA_W     = 24;  // Q16.8 vector component
  localparam int COEF_W     = 16;  // Q1.14 rotation element
  localparam int ROW_W      = 3 * COEF_W;
  localparam int VEC_W      = DATA_W + 1;         // after offset subtraction
  localparam int PROD_W     = VEC_W + COEF_W;     // vector times element
  localparam int SUM_W      = PROD_W + 2;         // three-term sum
  localparam int TP_W       = DATA_W + COEF_W;    // offset times element
  localparam int TS_W       = TP_W + 2;
  localparam int FRAC_SHIFT = 14;
  localparam int W_SHIFT    = 8;
  localparam int T_W        = TS_W - FRAC_SHIFT;  // unrotated offset
  localparam int QP_W       = VEC_W + T_W;        // normal times unrotated offset
  localparam int QS_W       = QP_W + 2;
  localparam int RS_W       = SUM_W - FRAC_SHIFT; // shifted rotation sum
  localparam int XYZ_W      = RS_W + 1;           // plus offset
  localparam int ND_W       = QS_W - W_SHIFT;
  localparam int WF_W       = ND_W + 1;           // plane distance before clamp

  localparam logic [DATA_W-1:0] SAT_MAX = 24'h7F_FFFF;
  localparam logic [DATA_W-1:0] SAT_MIN = 24'h80_0000;
  localparam logic [DATA_W-1:0] W_ONE   = 24'h00_0100;

  localparam logic [COEF_W-1:0] ONE_Q14  = 16'h4000;
  localparam logic [COEF_W-1:0] ZERO_Q14 = 16'h0000;

  typedef enum logic [2:0] {
    FUNC_ROTATE      = 3'd0,
    FUNC_UNROTATE    = 3'd1,
    FUNC_TRANSFORM   = 3'd2,
    FUNC_UNTRANSFORM = 3'd3,
    FUNC_PLANE       = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    CFG_ROW_FRONT = 3'd0,
    CFG_ROW_UP    = 3'd1,
    CFG_ROW_RIGHT = 3'd2,
    CFG_OFFSET_X  = 3'd3,
    CFG_OFFSET_Y  = 3'd4,
    CFG_OFFSET_Z  = 3'd5
  } cfg_idx_e;

  typedef logic [2:0][ROW_W-1:0]  rows_t;
  typedef logic [2:0][DATA_W-1:0] vec3_t;
  typedef logic [2:0][T_W-1:0]    tvec_t;

  // operands after selection: vector (or vector minus offset) and matrix
  typedef struct packed {
    func_e                         func;
    logic [2:0][VEC_W-1:0]         vec;
    logic [2:0][2:0][COEF_W-1:0]   coef;
    logic [DATA_W-1:0]             w;
  } op_t;

  typedef struct packed {
    func_e                         func;
    logic [2:0][2:0][PROD_W-1:0]   p;
    logic [2:0][QP_W-1:0]          q;
    logic [DATA_W-1:0]             w;
  } prod_t;

  typedef struct packed {
    func_e                         func;
    logic [2:0][SUM_W-1:0]         s;
    logic [QS_W-1:0]               q;
    logic [DATA_W-1:0]             w;
  } sum_t;

endpackage

/* hdl/avt_tcalc.sv */
// ---------------------------------------------------------------------------
// avt_tcalc
// Unrotated translation for plane transforms, rebuilt from the registers.
// ---------------------------------------------------------------------------
module avt_tcalc import avt_pkg::*; (
  input  logic  clk_i,
  input  rows_t row_i,
  input  vec3_t off_i,
  output tvec_t t_o
);

  logic signed [TP_W-1:0] prod_d [3][3];
  logic signed [TP_W-1:0] prod_q [3][3];
  tvec_t                  t_d;
  tvec_t                  t_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[i][j] = $signed(off_i[j]) * $signed(row_i[i][COEF_W*j +: COEF_W]);
      end
    end
  end

  always_comb begin
    logic signed [TS_W-1:0] acc;
    logic signed [TS_W-1:0] shf;
    t_d = '0;
    for (int i = 0; i < 3; i++) begin
      acc = TS_W'(prod_q[i][0]) + TS_W'(prod_q[i][1]) + TS_W'(prod_q[i][2]);
      shf = acc >>> FRAC_SHIFT;
      t_d[i] = shf[T_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    t_q    <= t_d;
  end

  assign t_o = t_q;

endmodule

/* hdl/avt_opsel.sv */
// ---------------------------------------------------------------------------
// avt_opsel
// First stage: subtract the offset for untransform, pick row or column form.
// ---------------------------------------------------------------------------
module avt_opsel import avt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  func_e             func_i,
  input  vec3_t             vec_i,
  input  logic [DATA_W-1:0] w_i,
  input  rows_t             row_i,
  input  vec3_t             off_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output op_t               op_o
);

  logic valid_q;
  logic ready;
  logic trans;
  op_t  op_d;
  op_t  op_q;

  assign ready = !valid_q || out_ready_i;

  // unrotate forms dot with rows, rotate forms sum columns
  assign trans = (func_i == FUNC_UNROTATE) || (func_i == FUNC_UNTRANSFORM);

  always_comb begin
    op_d      = '0;
    op_d.func = func_i;
    op_d.w    = w_i;
    for (int j = 0; j < 3; j++) begin
      if (func_i == FUNC_UNTRANSFORM) begin
        op_d.vec[j] = VEC_W'($signed(vec_i[j])) - VEC_W'($signed(off_i[j]));
      end else begin
        op_d.vec[j] = VEC_W'($signed(vec_i[j]));
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (trans) begin
          op_d.coef[i][j] = row_i[i][COEF_W*j +: COEF_W];
        end else begin
          op_d.coef[i][j] = row_i[j][COEF_W*i +: COEF_W];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      op_q <= op_d;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = valid_q;
  assign op_o        = op_q;

endmodule

/* hdl/avt_mac.sv */
// ---------------------------------------------------------------------------
// avt_mac
// Multiply stage and sum stage of the matrix-vector and plane dot products.
// ---------------------------------------------------------------------------
module avt_mac import avt_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  op_t   op_i,
  input  tvec_t t_i,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output sum_t  sum_o
);

  logic  prod_valid_q;
  logic  sum_valid_q;
  logic  prod_ready;
  logic  sum_ready;
  prod_t prod_d;
  prod_t prod_q;
  sum_t  sum_d;
  sum_t  sum_q;

  assign sum_ready  = !sum_valid_q || out_ready_i;
  assign prod_ready = !prod_valid_q || sum_ready;

  always_comb begin
    prod_d      = '0;
    prod_d.func = op_i.func;
    prod_d.w    = op_i.w;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d.p[i][j] = $signed(op_i.vec[j]) * $signed(op_i.coef[i][j]);
      end
      // normal dotted with the unrotated offset, used in plane mode only
      prod_d.q[i] = $signed(op_i.vec[i]) * $signed(t_i[i]);
    end
  end

  always_comb begin
    sum_d      = '0;
    sum_d.func = prod_q.func;
    sum_d.w    = prod_q.w;
    for (int i = 0; i < 3; i++) begin
      sum_d.s[i] = SUM_W'($signed(prod_q.p[i][0])) + SUM_W'($signed(prod_q.p[i][1]))
                 + SUM_W'($signed(prod_q.p[i][2]));
    end
    sum_d.q = QS_W'($signed(prod_q.q[0])) + QS_W'($signed(prod_q.q[1]))
            + QS_W'($signed(prod_q.q[2]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
      sum_valid_q  <= 1'b0;
    end else begin
      if (prod_ready) begin
        prod_valid_q <= in_valid_i;
      end
      if (sum_ready) begin
        sum_valid_q <= prod_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && prod_ready) begin
      prod_q <= prod_d;
    end
    if (prod_valid_q && sum_ready) begin
      sum_q <= sum_d;
    end
  end

  assign in_ready_o  = prod_ready;
  assign out_valid_o = sum_valid_q;
  assign sum_o       = sum_q;

endmodule

/* hdl/avt_outstage.sv */
// ---------------------------------------------------------------------------
// avt_outstage
// Scale, add translation, form w, clamp to 24 bits and hold the result.
// ---------------------------------------------------------------------------
module avt_outstage import avt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sum_t              sum_i,
  input  vec3_t             off_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output vec3_t             xyz_o,
  output logic [DATA_W-1:0] w_o,
  output logic              clip_o
);

  function automatic logic [DATA_W:0] sat_xyz(input logic signed [XYZ_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > $signed(XYZ_W'($signed(SAT_MAX)))) begin
      r = {1'b1, SAT_MAX};
    end else if (v < $signed(XYZ_W'($signed(SAT_MIN)))) begin
      r = {1'b1, SAT_MIN};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  function automatic logic [DATA_W:0] sat_w(input logic signed [WF_W-1:0] v);
    logic [DATA_W:0] r;
    if (v > $signed(WF_W'($signed(SAT_MAX)))) begin
      r = {1'b1, SAT_MAX};
    end else if (v < $signed(WF_W'($signed(SAT_MIN)))) begin
      r = {1'b1, SAT_MIN};
    end else begin
      r = {1'b0, v[DATA_W-1:0]};
    end
    return r;
  endfunction

  logic              valid_q;
  logic              ready;
  vec3_t             xyz_d;
  vec3_t             xyz_q;
  logic [DATA_W-1:0] w_d;
  logic [DATA_W-1:0] w_q;
  logic              clip_d;
  logic              clip_q;

  assign ready = !valid_q || out_ready_i;

  always_comb begin
    logic signed [SUM_W-1:0] st;
    logic signed [XYZ_W-1:0] full;
    logic signed [QS_W-1:0]  qs;
    logic signed [WF_W-1:0]  wfull;
    logic [DATA_W:0]         sr [3];
    logic [DATA_W:0]         wr;
    logic                    xyz_clip;

    for (int i = 0; i < 3; i++) begin
      st   = $signed(sum_i.s[i]) >>> FRAC_SHIFT;
      full = XYZ_W'($signed(st[RS_W-1:0]));
      if (sum_i.func == FUNC_TRANSFORM) begin
        full = full + XYZ_W'($signed(off_i[i]));
      end
      sr[i] = sat_xyz(full);
    end
    xyz_clip = sr[0][DATA_W] | sr[1][DATA_W] | sr[2][DATA_W];

    qs    = $signed(sum_i.q) >>> W_SHIFT;
    wfull = WF_W'($signed(sum_i.w)) - WF_W'($signed(qs[ND_W-1:0]));
    wr    = sat_w(wfull);

    xyz_d  = '0;
    w_d    = '0;
    clip_d = 1'b0;
    case (sum_i.func)
      FUNC_ROTATE, FUNC_UNROTATE, FUNC_UNTRANSFORM: begin
        for (int i = 0; i < 3; i++) xyz_d[i] = sr[i][DATA_W-1:0];
        clip_d = xyz_clip;
      end
      FUNC_TRANSFORM: begin
        for (int i = 0; i < 3; i++) xyz_d[i] = sr[i][DATA_W-1:0];
        w_d    = W_ONE;
        clip_d = xyz_clip;
      end
      FUNC_PLANE: begin
        for (int i = 0; i < 3; i++) xyz_d[i] = sr[i][DATA_W-1:0];
        w_d    = wr[DATA_W-1:0];
        clip_d = xyz_clip | wr[DATA_W];
      end
      default: begin
        // undefined codes give an all-zero result
        xyz_d  = '0;
        w_d    = '0;
        clip_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && ready) begin
      xyz_q  <= xyz_d;
      w_q    <= w_d;
      clip_q <= clip_d;
    end
  end

  assign in_ready_o  = ready;
  assign out_valid_o = valid_q;
  assign xyz_o       = xyz_q;
  assign w_o         = w_q;
  assign clip_o      = clip_q;

endmodule

/* hdl/affine_vector_transform_core.sv */
// ---------------------------------------------------------------------------
// affine_vector_transform_core
// Fixed-point 3D rotate / translate unit with a four-stage pipeline.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one vector per transaction, function code in
//   tuser. Output stream (m_axis): one result per input, in order, with the
//   saturation flag in tuser.
//   Config channel (cfg_*): writes rows and translation; always ready. Write
//   only while no transaction is in flight.
//   Pipeline: four register stages (operand select, multiply, sum,
//   scale/clamp). Throughput: one item per cycle, limited by the output
//   side and by settling: s_axis_tready stays low after reset and after
//   every config write while the unrotated translation for planes settles.
//   m_axis_tready runs back through the stage ready chain in the same cycle:
//   empty stages keep taking input, a full pipe drops s_axis_tready at once.
//   Reset clears all valid bits and loads the identity rotation and zero
//   translation.
// ---------------------------------------------------------------------------
`include "affine_vector_transform_core_assert.svh"

module affine_vector_transform_core import avt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic [2:0]  s_axis_tuser,   // func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
  output logic [0:0]  m_axis_tuser,   // clipped
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  rows_t             row_q;
  vec3_t             off_q;
  logic [1:0]        settle_q;
  logic              settled;
  tvec_t             t_vec;
  vec3_t             in_vec;
  logic              op_valid;
  logic              op_ready;
  logic              opsel_ready;
  op_t               op;
  logic              sum_valid;
  logic              sum_ready;
  sum_t              sum;
  vec3_t             out_xyz;
  logic [DATA_W-1:0] out_w;
  logic              out_clip;
  logic              rail_hit;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q[0] <= {ZERO_Q14, ZERO_Q14, ONE_Q14};
      row_q[1] <= {ZERO_Q14, ONE_Q14, ZERO_Q14};
      row_q[2] <= {ONE_Q14, ZERO_Q14, ZERO_Q14};
      off_q    <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ROW_FRONT: row_q[0] <= cfg_data_i;
        CFG_ROW_UP:    row_q[1] <= cfg_data_i;
        CFG_ROW_RIGHT: row_q[2] <= cfg_data_i;
        CFG_OFFSET_X:  off_q[0] <= cfg_data_i[DATA_W-1:0];
        CFG_OFFSET_Y:  off_q[1] <= cfg_data_i[DATA_W-1:0];
        CFG_OFFSET_Z:  off_q[2] <= cfg_data_i[DATA_W-1:0];
        default: ;
      endcase
    end
  end

  // hold input off until the unrotated translation has caught up
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q <= 2'd3;
    end else if (cfg_valid_i) begin
      settle_q <= 2'd3;
    end else if (settle_q != 2'd0) begin
      settle_q <= settle_q - 2'd1;
    end
  end

  assign settled = (settle_q == 2'd0);

  avt_tcalc u_tcalc (
    .clk_i (clk_i),
    .row_i (row_q),
    .off_i (off_q),
    .t_o   (t_vec)
  );

  assign in_vec[0] = s_axis_tdata[23:0];
  assign in_vec[1] = s_axis_tdata[47:24];
  assign in_vec[2] = s_axis_tdata[71:48];

  avt_opsel u_opsel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid && settled),
    .in_ready_o  (opsel_ready),
    .func_i      (func_e'(s_axis_tuser)),
    .vec_i       (in_vec),
    .w_i         (s_axis_tdata[95:72]),
    .row_i       (row_q),
    .off_i       (off_q),
    .out_valid_o (op_valid),
    .out_ready_i (op_ready),
    .op_o        (op)
  );

  assign s_axis_tready = opsel_ready && settled;

  avt_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (op_valid),
    .in_ready_o  (op_ready),
    .op_i        (op),
    .t_i         (t_vec),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .sum_o       (sum)
  );

  avt_outstage u_outstage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sum_valid),
    .in_ready_o  (sum_ready),
    .sum_i       (sum),
    .off_i       (off_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .xyz_o       (out_xyz),
    .w_o         (out_w),
    .clip_o      (out_clip)
  );

  assign m_axis_tdata = {out_w, out_xyz[2], out_xyz[1], out_xyz[0]};
  assign m_axis_tuser = out_clip;

  // at least one output component sits on a saturation rail
  assign rail_hit = (m_axis_tdata[23:0] == SAT_MAX) || (m_axis_tdata[23:0] == SAT_MIN)
                 || (m_axis_tdata[47:24] == SAT_MAX) || (m_axis_tdata[47:24] == SAT_MIN)
                 || (m_axis_tdata[71:48] == SAT_MAX) || (m_axis_tdata[71:48] == SAT_MIN)
                 || (m_axis_tdata[95:72] == SAT_MAX) || (m_axis_tdata[95:72] == SAT_MIN);

  `AVT_ASSERT_NOW(a_settle_blocks_input, settle_q != 2'd0, !s_axis_tready)
  `AVT_ASSERT_NEXT(a_cfg_write_blocks_input, cfg_valid_i && cfg_ready_o, !s_axis_tready)
  `AVT_ASSERT_NEXT(a_accept_fills_first_stage, s_axis_tvalid && s_axis_tready, op_valid)
  `AVT_ASSERT_NOW(a_clip_at_rail, m_axis_tvalid && m_axis_tuser[0], rail_hit)

endmodule

/* dv/avt_result_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// avt_result_checker
// Mirrors the rotation rows and translation from the config channel, works
// out the result of every input transaction and compares each output
// transaction, field by field, with the oldest outstanding prediction.
// ---------------------------------------------------------------------------
module avt_result_checker import avt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,   // in_x, in_y, in_z, in_w
  input  logic [2:0]  s_axis_tuser,   // func
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,   // out_x, out_y, out_z, out_w
  input  logic [0:0]  m_axis_tuser,   // clipped
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output int          mismatches_o,
  output int          outstanding_o
);

  localparam longint OUT_MAX = 8388607;
  localparam longint OUT_MIN = -8388608;

  typedef struct packed {
    logic [DATA_W-1:0] x, y, z, w;
    logic              clipped;
  } vec_result_t;

  logic [ROW_W-1:0] front_row;
  logic [ROW_W-1:0] up_row;
  logic [ROW_W-1:0] right_row;
  longint           offset_v[3];
  vec_result_t      pending_results_q[$];
  vec_result_t      oldest;
  int               fail_count;

  function automatic longint coef_of(logic [ROW_W-1:0] row, int k);
    logic signed [COEF_W-1:0] c;
    c = row[COEF_W*k +: COEF_W];
    return longint'(c);
  endfunction

  function automatic logic [ROW_W-1:0] row_sel(int k);
    case (k)
      0:       return front_row;
      1:       return up_row;
      default: return right_row;
    endcase
  endfunction

  // three-component dot product with one row, before scaling
  function automatic longint row_dot(longint a, longint b, longint c, logic [ROW_W-1:0] row);
    return a * coef_of(row, 0) + b * coef_of(row, 1) + c * coef_of(row, 2);
  endfunction

  // component k of the rows scaled by the vector, before scaling
  function automatic longint rotate_sum(longint a, longint b, longint c, int k);
    return a * coef_of(front_row, k) + b * coef_of(up_row, k) + c * coef_of(right_row, k);
  endfunction

  function automatic logic [DATA_W-1:0] clamp24(longint val, inout bit clip);
    longint lim;
    lim = val;
    if (val > OUT_MAX) begin
      lim  = OUT_MAX;
      clip = 1'b1;
    end else if (val < OUT_MIN) begin
      lim  = OUT_MIN;
      clip = 1'b1;
    end
    return lim[DATA_W-1:0];
  endfunction

  function automatic vec_result_t transform_vector(logic [2:0] fn, logic [95:0] payload);
    longint      v[3];
    longint      t[3];
    longint      r[4];
    longint      nd;
    longint      wv;
    bit          clip;
    vec_result_t res;
    clip = 1'b0;
    for (int k = 0; k < 4; k++) r[k] = 0;
    for (int k = 0; k < 3; k++) v[k] = longint'($signed(payload[DATA_W*k +: DATA_W]));
    wv = longint'($signed(payload[4*DATA_W-1 -: DATA_W]));
    // untransform works on the vector minus the translation, unclamped
    if (fn == FUNC_UNTRANSFORM) begin
      for (int k = 0; k < 3; k++) v[k] = v[k] - offset_v[k];
    end
    case (fn)
      FUNC_ROTATE, FUNC_PLANE: begin
        for (int k = 0; k < 3; k++)
          r[k] = clamp24(rotate_sum(v[0], v[1], v[2], k) >>> FRAC_SHIFT, clip);
        if (fn == FUNC_PLANE) begin
          for (int k = 0; k < 3; k++)
            t[k] = row_dot(offset_v[0], offset_v[1], offset_v[2], row_sel(k)) >>> FRAC_SHIFT;
          nd   = (v[0] * t[0] + v[1] * t[1] + v[2] * t[2]) >>> W_SHIFT;
          r[3] = clamp24(wv - nd, clip);
        end
      end
      FUNC_UNROTATE, FUNC_UNTRANSFORM: begin
        for (int k = 0; k < 3; k++)
          r[k] = clamp24(row_dot(v[0], v[1], v[2], row_sel(k)) >>> FRAC_SHIFT, clip);
      end
      FUNC_TRANSFORM: begin
        for (int k = 0; k < 3; k++)
          r[k] = clamp24((rotate_sum(v[0], v[1], v[2], k) >>> FRAC_SHIFT) + offset_v[k], clip);
        r[3] = W_ONE;
      end
      default: ;  // undefined codes give an all-zero result
    endcase
    res.x       = r[0][DATA_W-1:0];
    res.y       = r[1][DATA_W-1:0];
    res.z       = r[2][DATA_W-1:0];
    res.w       = r[3][DATA_W-1:0];
    res.clipped = clip;
    return res;
  endfunction

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_row   = {ZERO_Q14, ZERO_Q14, ONE_Q14};
      up_row      = {ZERO_Q14, ONE_Q14, ZERO_Q14};
      right_row   = {ONE_Q14, ZERO_Q14, ZERO_Q14};
      offset_v[0] = 0;
      offset_v[1] = 0;
      offset_v[2] = 0;
      fail_count  = 0;
      pending_results_q.delete();
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ROW_FRONT: front_row   = cfg_data_i;
          CFG_ROW_UP:    up_row      = cfg_data_i;
          CFG_ROW_RIGHT: right_row   = cfg_data_i;
          CFG_OFFSET_X:  offset_v[0] = longint'($signed(cfg_data_i[DATA_W-1:0]));
          CFG_OFFSET_Y:  offset_v[1] = longint'($signed(cfg_data_i[DATA_W-1:0]));
          CFG_OFFSET_Z:  offset_v[2] = longint'($signed(cfg_data_i[DATA_W-1:0]));
          default: ;  // spare index: registers stay as they are
        endcase
      end
      // retire before accepting, so a result can never match its own input
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results_q.size() == 0) begin
          $error("result with no prediction outstanding: out_x %0d",
                 $signed(m_axis_tdata[DATA_W-1:0]));
          fail_count++;
        end else begin
          oldest = pending_results_q.pop_front();
          check_field("out_x", oldest.x, m_axis_tdata[DATA_W-1:0]);
          check_field("out_y", oldest.y, m_axis_tdata[2*DATA_W-1 -: DATA_W]);
          check_field("out_z", oldest.z, m_axis_tdata[3*DATA_W-1 -: DATA_W]);
          check_field("out_w", oldest.w, m_axis_tdata[4*DATA_W-1 -: DATA_W]);
          check_field("clipped", {23'd0, oldest.clipped}, {23'd0, m_axis_tuser[0]});
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_results_q.push_back(transform_vector(s_axis_tuser, s_axis_tdata));
      outstanding_o <= pending_results_q.size();
      mismatches_o  <= fail_count;
    end
  end

endmodule

/* dv/tb_affine_vector_transform_core.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_affine_vector_transform_core
// Drives vectors and planes through the transform core under a series of
// rotation and translation settings, with random idling on both streams and
// long output stalls; the checker beside the core predicts every result.
// ---------------------------------------------------------------------------
module tb_affine_vector_transform_core;
  import avt_pkg::*;

  // function codes the core does not define
  localparam logic [2:0] FUNC_RSVD_A = 3'd5;
  localparam logic [2:0] FUNC_RSVD_B = 3'd6;
  localparam logic [2:0] FUNC_RSVD_C = 3'd7;
  // register indexes beyond the list
  localparam logic [2:0] CFG_RSVD_A  = 3'd6;
  localparam logic [2:0] CFG_RSVD_B  = 3'd7;

  localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;

  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS   = 74;
  localparam int LONG_HOLD     = 80;
  localparam int END_LIMIT     = 20000;
  localparam int SETTLE_CYCLES = 8;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata;   // in_x, in_y, in_z, in_w
  logic [2:0]  s_axis_tuser;   // func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [95:0] m_axis_tdata;   // out_x, out_y, out_z, out_w
  logic [0:0]  m_axis_tuser;   // clipped
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_data_i;

  int mismatches;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  bit hold_req;
  int end_wait;

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  affine_vector_transform_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  avt_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // output side: random back-pressure, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    #(3_000_000);
    $display("end of test: mismatches");
    $finish;
  end

  function automatic logic [95:0] pack_vec(logic [DATA_W-1:0] x, logic [DATA_W-1:0] y,
                                           logic [DATA_W-1:0] z, logic [DATA_W-1:0] w);
    return {w, z, y, x};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  // mix of extremes, small magnitudes and full-range values
  function automatic logic [DATA_W-1:0] rand_comp();
    case ($urandom_range(9))
      0:       return SAT_MAX;
      1:       return SAT_MIN;
      2, 3, 4: return 24'($urandom_range(8191)) - 24'd4096;
      default: return 24'($urandom());
    endcase
  endfunction

  function automatic logic [2:0] rand_func();
    if ($urandom_range(9) == 0) return 3'($urandom_range(FUNC_RSVD_C, FUNC_RSVD_A));
    return 3'($urandom_range(FUNC_PLANE, FUNC_ROTATE));
  endfunction

  // leaves tvalid high after the transaction; the next call decides
  task automatic send_item(input logic [2:0] fn, input logic [95:0] payload);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= payload;
    s_axis_tuser  <= fn;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic program_config(input int style);
    logic [ROW_W-1:0]  rows[3];
    logic [DATA_W-1:0] offs[3];
    case (style)
      0: begin
        rows[0] = {ZERO_Q14, ZERO_Q14, ONE_Q14};
        rows[1] = {ZERO_Q14, ONE_Q14, ZERO_Q14};
        rows[2] = {ONE_Q14, ZERO_Q14, ZERO_Q14};
        for (int k = 0; k < 3; k++) offs[k] = 24'($urandom_range(65535)) - 24'd32768;
      end
      1: begin
        for (int k = 0; k < 3; k++) begin
          rows[k] = rand48();
          offs[k] = 24'($urandom());
        end
      end
      2: begin
        for (int k = 0; k < 3; k++) begin
          rows[k] = {3{COEF_POS_MAX}};
          offs[k] = SAT_MAX;
        end
      end
      3: begin
        for (int k = 0; k < 3; k++) begin
          rows[k] = {3{COEF_NEG_MAX}};
          offs[k] = SAT_MIN;
        end
      end
      default: begin
        // elements within +/-1.0, as a real rotation would have
        for (int k = 0; k < 3; k++) begin
          for (int j = 0; j < 3; j++)
            rows[k][COEF_W*j +: COEF_W] = 16'(int'($urandom_range(32768)) - 16384);
          offs[k] = 24'($urandom());
        end
      end
    endcase
    write_reg(CFG_ROW_FRONT, rows[0]);
    write_reg(CFG_RSVD_A, rand48());
    write_reg(CFG_ROW_UP, rows[1]);
    write_reg(CFG_ROW_RIGHT, rows[2]);
    // junk above bit 23 must be dropped
    write_reg(CFG_OFFSET_X, {24'($urandom()), offs[0]});
    write_reg(CFG_OFFSET_Y, {24'($urandom()), offs[1]});
    write_reg(CFG_OFFSET_Z, {24'($urandom()), offs[2]});
    write_reg(CFG_RSVD_B, rand48());
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_ROTATE;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= CFG_ROW_FRONT;
    cfg_data_i    <= '0;
    hold_req      = 1'b0;
    hold_left     = 0;
    send_idle_pct = 17;
    recv_idle_pct = 46;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // identity rotation, zero translation straight out of reset
    send_item(FUNC_ROTATE,      pack_vec(SAT_MAX, SAT_MIN, '0, '0));
    send_item(FUNC_UNROTATE,    pack_vec(SAT_MIN, SAT_MAX, '1, '0));
    send_item(FUNC_TRANSFORM,   pack_vec(SAT_MAX, SAT_MAX, SAT_MAX, '0));
    send_item(FUNC_UNTRANSFORM, pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX));
    send_item(FUNC_PLANE,       pack_vec(24'd1, '1, SAT_MAX, SAT_MIN));
    send_item(FUNC_RSVD_A,      pack_vec(SAT_MAX, SAT_MIN, 24'd1, SAT_MAX));
    send_item(FUNC_RSVD_B,      pack_vec(SAT_MIN, SAT_MAX, '1, SAT_MIN));
    send_item(FUNC_RSVD_C,      pack_vec('1, '1, '1, '1));

    // largest positive elements and translation: drive every path into clamp
    wait_results_drained();
    program_config(2);
    send_item(FUNC_ROTATE,      pack_vec(SAT_MAX, SAT_MAX, SAT_MAX, '0));
    send_item(FUNC_UNROTATE,    pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, '0));
    send_item(FUNC_TRANSFORM,   pack_vec(SAT_MAX, SAT_MAX, SAT_MAX, '0));
    send_item(FUNC_UNTRANSFORM, pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, '0));
    send_item(FUNC_PLANE,       pack_vec(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MIN));

    // most negative elements and translation
    wait_results_drained();
    program_config(3);
    send_item(FUNC_ROTATE,      pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, '0));
    send_item(FUNC_TRANSFORM,   pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, '0));
    send_item(FUNC_UNTRANSFORM, pack_vec(SAT_MAX, SAT_MAX, SAT_MAX, '0));
    send_item(FUNC_PLANE,       pack_vec(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MAX));

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 17;
      end
      if (phase == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_results_drained();
      program_config(phase < 5 ? phase : int'($urandom_range(4)));
      // stall the output long enough to fill the pipe and back up the input
      if (phase == 1 || phase == 7) hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 4 && n == PHASE_ITEMS / 2) wait_results_drained();
        send_item(rand_func(), pack_vec(rand_comp(), rand_comp(), rand_comp(), rand_comp()));
      end
    end

    s_axis_tvalid <= 1'b0;
    end_wait = 0;
    do begin
      @(posedge clk_i);
      end_wait++;
    end while (outstanding != 0 && end_wait < END_LIMIT);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (outstanding != 0) $error("%0d predicted results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hdl
hdl/avt_pkg.sv
hdl/avt_tcalc.sv
hdl/avt_opsel.sv
hdl/avt_mac.sv
hdl/avt_outstage.sv
hdl/affine_vector_transform_core.sv
dv/avt_result_checker.sv
dv/tb_affine_vector_transform_core.sv
